>>> design/ws2812_pkg.sv
package ws2812_pkg;

  localparam int LED_COUNT_DEF      = 32;
  localparam int GRADIENT_STEPS_DEF = 20;
  localparam int BITS_PER_LED       = 24;
  localparam int POS_W              = 10;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_BAR   = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] REG_CODE_ONE  = 2'd0;
  localparam logic [1:0] REG_CODE_ZERO = 2'd1;
  localparam logic [1:0] REG_TAIL_BITS = 2'd2;

  typedef logic [BITS_PER_LED-1:0] color_t;

  // blue-to-green bar gradient, packed green, red, blue
  function automatic color_t grad_color(input logic [7:0] k);
    color_t c;
    case (k)
      8'd0:    c = 24'h000014;
      8'd1:    c = 24'h000012;
      8'd2:    c = 24'h000010;
      8'd3:    c = 24'h00000E;
      8'd4:    c = 24'h00000C;
      8'd5:    c = 24'h01000A;
      8'd6:    c = 24'h020009;
      8'd7:    c = 24'h030008;
      8'd8:    c = 24'h040007;
      8'd9:    c = 24'h050006;
      8'd10:   c = 24'h060005;
      8'd11:   c = 24'h070004;
      8'd12:   c = 24'h080003;
      8'd13:   c = 24'h090002;
      8'd14:   c = 24'h0A0001;
      8'd15:   c = 24'h0C0000;
      8'd16:   c = 24'h0E0000;
      8'd17:   c = 24'h100000;
      8'd18:   c = 24'h120000;
      8'd19:   c = 24'h140000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

>>> design/ws2812_strip_frame_encoder.sv
// WS2812 strip frame encoder. Holds one 24-bit colour per LED and, one tick beat at a
// time, hands out the PWM compare value of the next bit of the frame (green, red, blue,
// MSB first), followed by tail_bits zero codes. Write, clear and bar requests update the
// store and restart the frame; every input beat gives exactly one result beat. A write
// or an idle tick gives its result straight from the idle state, a frame tick passes
// through a store read state and a decode state, and clear or bar sweeps the colour
// store one entry per cycle first. After reset a like sweep clears the store before
// in_ready rises. The block takes no new beat until the result has been taken.
module ws2812_strip_frame_encoder
  import ws2812_pkg::*;
#(
  parameter int LED_COUNT      = LED_COUNT_DEF,
  parameter int GRADIENT_STEPS = GRADIENT_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  led_index,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic [7:0]  blue,
  input  logic [7:0]  bar_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pwm_duty,
  output logic        bit_valid,
  output logic        frame_last,
  output logic        busy_res,
  output logic        index_rejected
);

  localparam int AW         = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int DATA_CODES = LED_COUNT * BITS_PER_LED;
  localparam int BAR_MAX    = (GRADIENT_STEPS < LED_COUNT) ? GRADIENT_STEPS : LED_COUNT;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SWEEP = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]       state;
  logic [15:0]      code_one;
  logic [15:0]      code_zero;
  logic [7:0]       tail_bits;
  logic             sending;
  logic [POS_W-1:0] code_pos;
  logic [AW-1:0]    led_cnt;
  logic [4:0]       bit_cnt;
  logic [AW-1:0]    sweep_cnt;
  logic [4:0]       sweep_n;
  logic             sweep_res;

  color_t           store [LED_COUNT];
  color_t           rd_word;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  color_t           mem_wdata;

  logic             accept;
  logic             idx_ok;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   total;
  logic             in_data;
  logic             at_end;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = ({1'b0, led_index} < 9'(LED_COUNT));
  assign pos_inc  = {1'b0, code_pos} + 1'b1;
  assign total    = (POS_W+1)'(DATA_CODES) + {3'b0, tail_bits};
  assign in_data  = ({1'b0, code_pos} < (POS_W+1)'(DATA_CODES));
  assign at_end   = (pos_inc >= total);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = sweep_cnt;
    mem_wdata = '0;
    if (state == ST_SWEEP) begin
      mem_we = 1'b1;
      if ({3'b0, sweep_n} > 8'(sweep_cnt)) begin
        mem_wdata = grad_color(8'(sweep_cnt));
      end
    end else if (accept && req_type == REQ_WRITE && idx_ok) begin
      mem_we    = 1'b1;
      mem_addr  = AW'(led_index);
      mem_wdata = {green, red, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    rd_word <= store[led_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_one  <= '0;
      code_zero <= '0;
      tail_bits <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_ONE:  code_one  <= cfg_data;
        REG_CODE_ZERO: code_zero <= cfg_data;
        REG_TAIL_BITS: tail_bits <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;   // clearing pass after reset
      sweep_cnt <= '0;
      sweep_n   <= '0;
      sweep_res <= 1'b0;
      sending   <= 1'b0;
      code_pos  <= '0;
      led_cnt   <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pwm_duty       <= '0;
            bit_valid      <= 1'b0;
            frame_last     <= 1'b0;
            index_rejected <= (req_type == REQ_WRITE) && !idx_ok;
            case (req_type)
              REQ_WRITE: begin
                busy_res       <= 1'b1;
                sending        <= 1'b1;
                code_pos       <= '0;
                led_cnt        <= '0;
                bit_cnt        <= '0;
                out_valid      <= 1'b1;
                state          <= ST_EMIT;
              end
              REQ_CLEAR, REQ_BAR: begin
                sweep_cnt <= '0;
                sweep_res <= 1'b1;
                if (req_type == REQ_CLEAR) begin
                  sweep_n <= '0;
                end else if (bar_count > 8'(BAR_MAX)) begin
                  sweep_n <= 5'(BAR_MAX);
                end else begin
                  sweep_n <= bar_count[4:0];
                end
                state <= ST_SWEEP;
              end
              default: begin
                if (sending) begin
                  state <= ST_READ;
                end else begin
                  busy_res  <= 1'b0;
                  out_valid <= 1'b1;
                  state     <= ST_EMIT;
                end
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == AW'(LED_COUNT - 1)) begin
            if (sweep_res) begin
              busy_res  <= 1'b1;
              sending   <= 1'b1;
              code_pos  <= '0;
              led_cnt   <= '0;
              bit_cnt   <= '0;
              out_valid <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (!in_data) begin
            pwm_duty <= '0;
          end else if (rd_word[5'(BITS_PER_LED - 1) - bit_cnt]) begin
            pwm_duty <= code_one;
          end else begin
            pwm_duty <= code_zero;
          end
          bit_valid <= 1'b1;
          if (at_end) begin
            frame_last <= 1'b1;
            busy_res   <= 1'b0;
            sending    <= 1'b0;
            code_pos   <= '0;
            led_cnt    <= '0;
            bit_cnt    <= '0;
          end else begin
            frame_last <= 1'b0;
            busy_res   <= 1'b1;
            code_pos   <= pos_inc[POS_W-1:0];
            if (bit_cnt == 5'(BITS_PER_LED - 1)) begin
              bit_cnt <= '0;
              // hold on the last LED once the data part is done
              if (led_cnt != AW'(LED_COUNT - 1)) begin
                led_cnt <= led_cnt + 1'b1;
              end
            end else begin
              bit_cnt <= bit_cnt + 1'b1;
            end
          end
          out_valid <= 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last) |-> (bit_valid && !busy_res && !sending))
    else $error("frame end without a code or still busy");

  a_reject_is_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_rejected) |-> (!bit_valid && busy_res))
    else $error("rejected index on a non-write beat");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (code_pos == '0 && bit_cnt == '0))
    else $error("position counters not cleared while idle");
`endif

endmodule

>>> sim/ws2812_strip_frame_encoder_tb.sv
module ws2812_strip_frame_encoder_tb
  import ws2812_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LED_N       = LED_COUNT_DEF;
  localparam int GRAD_N      = GRADIENT_STEPS_DEF;
  localparam int DATA_CODES  = LED_N * BITS_PER_LED;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;

  // bar ramp, packed green, red, blue
  localparam color_t BAR_RAMP [GRAD_N] = '{
    24'h000014, 24'h000012, 24'h000010, 24'h00000E, 24'h00000C,
    24'h01000A, 24'h020009, 24'h030008, 24'h040007, 24'h050006,
    24'h060005, 24'h070004, 24'h080003, 24'h090002, 24'h0A0001,
    24'h0C0000, 24'h0E0000, 24'h100000, 24'h120000, 24'h140000
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic [7:0] bars;
    logic       typed;
    logic       want_busy;
    logic       want_rej;
  } strip_req_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        valid;
    logic        last;
    logic        busy;
    logic        rej;
  } strip_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_CODE_ONE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_TICK;
  logic [7:0]  led_index = '0;
  logic [7:0]  green = '0;
  logic [7:0]  red = '0;
  logic [7:0]  blue = '0;
  logic [7:0]  bar_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] pwm_duty;
  logic        bit_valid;
  logic        frame_last;
  logic        busy_res;
  logic        index_rejected;

  ws2812_strip_frame_encoder dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the strip
  color_t      led_colors [LED_N];
  int unsigned code_pos;
  logic        frame_live;
  logic [15:0] duty_one;
  logic [15:0] duty_zero;
  logic [7:0]  latch_len;

  strip_req_t send_q [$];
  strip_res_t pending_codes [$];
  strip_req_t cur_beat;
  strip_res_t want_code;
  strip_res_t got_code;

  int queued_total  = 0;
  int checked_total = 0;
  int errors        = 0;
  int frames_done   = 0;
  int rejects_seen  = 0;
  int bar_loads     = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  int cycle_count   = 0;
  bit calm          = 1'b0;
  bit long_hold_go  = 1'b0;
  bit hold_used     = 1'b0;

  function automatic strip_res_t step_strip(input strip_req_t q);
    strip_res_t  res;
    int unsigned lit;
    int unsigned p;
    int unsigned total;
    color_t      word;
    res = '0;
    case (q.kind)
      REQ_WRITE: begin
        if (q.idx < LED_N) led_colors[q.idx] = {q.g, q.r, q.b};
        else res.rej = 1'b1;
        code_pos = 0;
        frame_live = 1'b1;
      end
      REQ_CLEAR: begin
        foreach (led_colors[k]) led_colors[k] = '0;
        code_pos = 0;
        frame_live = 1'b1;
      end
      REQ_BAR: begin
        lit = (q.bars > GRAD_N) ? GRAD_N : q.bars;
        if (lit > LED_N) lit = LED_N;
        foreach (led_colors[k]) led_colors[k] = '0;
        for (int k = 0; k < lit; k++) led_colors[k] = BAR_RAMP[k];
        code_pos = 0;
        frame_live = 1'b1;
      end
      default: begin
        if (frame_live) begin
          total = DATA_CODES + latch_len;
          p = code_pos;
          if (p < DATA_CODES) begin
            word = led_colors[p / BITS_PER_LED];
            res.duty = word[BITS_PER_LED - 1 - (p % BITS_PER_LED)] ? duty_one : duty_zero;
          end
          res.valid = 1'b1;
          // >= also covers a tail that was shortened below what has gone out
          if (p + 1 >= total) begin
            res.last = 1'b1;
            frame_live = 1'b0;
            code_pos = 0;
          end else begin
            code_pos = p + 1;
          end
        end
      end
    endcase
    res.busy = frame_live;
    return res;
  endfunction

  function automatic strip_req_t row(input logic [1:0] kind, input logic [7:0] idx, g, r, b,
                                     bars, input logic typed, busy, rej);
    strip_req_t x;
    x.kind = kind;
    x.idx = idx;
    x.g = g;
    x.r = r;
    x.b = b;
    x.bars = bars;
    x.typed = typed;
    x.want_busy = busy;
    x.want_rej = rej;
    return x;
  endfunction

  function automatic strip_req_t noise_tick();
    return row(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic strip_req_t random_write(input logic [7:0] idx);
    if ($urandom_range(0, 7) == 0)
      return row(REQ_WRITE, idx, 8'h00, 8'h00, 8'h00, 8'($urandom), 1'b0, 1'b0, 1'b0);
    return row(REQ_WRITE, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'b0, 1'b0, 1'b0);
  endfunction

  task automatic offer(input strip_req_t q);
    send_q.push_back(q);
    queued_total++;
  endtask

  task automatic drain_wait();
    while (checked_total != queued_total) @(posedge clk);
  endtask

  task automatic settle();
    drain_wait();
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic program_regs(input logic [15:0] one, zero, input logic [7:0] tail);
    write_reg(REG_CODE_ONE, one);
    write_reg(REG_CODE_ZERO, zero);
    write_reg(REG_TAIL_BITS, {8'h00, tail});
    cfg_we <= 1'b0;
    duty_one = one;
    duty_zero = zero;
    latch_len = tail;
  endtask

  task automatic queue_mix(input int n);
    int left;
    int pick;
    int run;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run = $urandom_range(1, 40);
        repeat (run) offer(noise_tick());
        left -= run;
      end else begin
        if (pick < 78)
          offer(random_write(($urandom_range(0, 6) == 0) ? 8'($urandom_range(32, 255))
                                                         : 8'($urandom_range(0, 31))));
        else if (pick < 86)
          offer(row(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 1'b0, 1'b0, 1'b0));
        else
          offer(row(REQ_BAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    $urandom_range(0, 1) ? 8'($urandom_range(0, 24)) : 8'($urandom),
                    1'b0, 1'b0, 1'b0));
        left--;
      end
      // sender waits for the block to empty now and then, frame still running
      if ($urandom_range(0, 29) == 0) drain_wait();
    end
  endtask

  // sender, also feeds the predictor with each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want_code = step_strip(cur_beat);
        if (cur_beat.typed)
          want_code = '{duty: 16'h0000, valid: 1'b0, last: 1'b0,
                        busy: cur_beat.want_busy, rej: cur_beat.want_rej};
        if (cur_beat.kind == REQ_BAR) bar_loads++;
        pending_codes.push_back(want_code);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (send_q.size() != 0) begin
          cur_beat = send_q.pop_front();
          req_type <= cur_beat.kind;
          led_index <= cur_beat.idx;
          green <= cur_beat.g;
          red <= cur_beat.r;
          blue <= cur_beat.b;
          bar_count <= cur_beat.bars;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      got_code = '{duty: pwm_duty, valid: bit_valid, last: frame_last,
                   busy: busy_res, rej: index_rejected};
      if (pending_codes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with nothing outstanding");
      end else begin
        want_code = pending_codes.pop_front();
        if (got_code.duty !== want_code.duty || got_code.valid !== want_code.valid ||
            got_code.last !== want_code.last || got_code.busy !== want_code.busy ||
            got_code.rej !== want_code.rej) begin
          errors++;
          if (errors <= 10)
            $display("ERROR beat %0d: got duty %h valid %b last %b busy %b rej %b, %s",
                     checked_total, got_code.duty, got_code.valid, got_code.last,
                     got_code.busy, got_code.rej,
                     $sformatf("want duty %h valid %b last %b busy %b rej %b",
                               want_code.duty, want_code.valid, want_code.last,
                               want_code.busy, want_code.rej));
        end
        if (got_code.last) frames_done++;
        if (got_code.rej) rejects_seen++;
        checked_total++;
      end
    end
    if (long_hold_go && !hold_used) begin
      hold_used = 1'b1;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ws2812_strip_frame_encoder: mismatch");
      $finish;
    end
  end

  initial begin
    strip_req_t directed_rows [$];
    foreach (led_colors[k]) led_colors[k] = '0;
    code_pos = 0;
    frame_live = 1'b0;
    duty_one = '0;
    duty_zero = '0;
    latch_len = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // block sweeps its store after reset
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    program_regs(16'hFFFF, 16'h0000, 8'd0);

    //                      kind       idx     g       r       b       bars   typed busy rej
    directed_rows.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_WRITE, 8'd0,  8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_WRITE, 8'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_WRITE, 8'd32, 8'h12, 8'h34, 8'h56, 8'h00, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(row(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    directed_rows.push_back(row(REQ_WRITE, 8'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_BAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'd0,  1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_BAR,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd20, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_BAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_BAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'd21, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_BAR,   8'h00, 8'h00, 8'h00, 8'h00, 8'd5,  1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    directed_rows.push_back(row(REQ_WRITE, 8'd1,  8'h80, 8'h01, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b0));
    directed_rows.push_back(row(REQ_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
    foreach (directed_rows[i]) offer(directed_rows[i]);
    settle();

    program_regs(16'($urandom), 16'($urandom), 8'($urandom_range(0, 8)));
    queue_mix(120);
    settle();

    // receiver holds off for a long stretch while the sender keeps offering
    program_regs(16'h0000, 16'hFFFF, 8'($urandom_range(0, 8)));
    long_hold_go = 1'b1;
    queue_mix(120);
    settle();

    // whole frame with no tail, store filled with random colours
    program_regs(16'($urandom), 16'($urandom), 8'd0);
    for (int k = 0; k < LED_N; k++) offer(random_write(8'(k)));
    repeat (DATA_CODES + 3) offer(noise_tick());
    settle();

    // no idling from here on; run into a long tail, then cut the tail short
    calm = 1'b1;
    program_regs(16'($urandom), 16'($urandom), 8'd255);
    repeat (8) offer(random_write(8'($urandom_range(0, LED_N - 1))));
    repeat (DATA_CODES + 7) offer(noise_tick());
    settle();
    program_regs(16'($urandom), 16'($urandom), 8'd4);
    repeat (3) offer(noise_tick());
    settle();

    $display("covered %0d beats over six register settings: %0d frames ended,", checked_total,
             frames_done);
    $display("%0d out-of-range writes flagged, %0d bar loads, %0d errors", rejects_seen,
             bar_loads, errors);
    if (errors == 0) begin
      $display("ws2812_strip_frame_encoder: match");
    end else begin
      $display("ws2812_strip_frame_encoder: mismatch");
    end
    $finish;
  end

endmodule
